@@ design/lgu_pkg.sv @@
// Shared types and constants for the loss and gradient unit.
package lgu_pkg;

   localparam int DIVD_W  = 42;     // divider dividend width (k << 30 for k < 4096)
   localparam int DVSR_W  = 24;     // divider divisor width (x <= 2^23)
   localparam int LN2_Q16 = 45426;  // ln 2 in Q16
   localparam int TERM_MAX_D = 80;  // series stops once the odd divisor reaches this

   localparam logic [0:0] MODE_HALF_SQ = 1'b0;
   localparam logic [0:0] MODE_XENT    = 1'b1;

   localparam logic [0:0] REG_LOSS_MODE = 1'b0;

   typedef struct packed {
      logic signed [23:0] prediction;
      logic signed [23:0] target;
      logic               last;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] gradient;
      logic signed [47:0] vector_loss;
      logic signed [47:0] loss_total;
      logic               done_res;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_FILL_ZS,
      ST_FILL_ZW,
      ST_FILL_Z2,
      ST_FILL_LOOP,
      ST_FILL_TW,
      ST_FILL_TM,
      ST_FILL_WR,
      ST_IDLE,
      ST_SE_MUL,
      ST_CE_DS,
      ST_CE_DW,
      ST_CE_NORM,
      ST_CE_IDX,
      ST_CE_RD,
      ST_CE_LN,
      ST_CE_MUL,
      ST_DONE
   } state_type;

endpackage

@@ design/loss_and_gradient_unit.sv @@
// Loss and gradient unit: half squared error and cross entropy, top level.
//
// One request carries a prediction/target pair (signed Q8.16) and a last flag;
// each request yields one response with the element gradient (Q16.16,
// saturated), and on last the vector loss and the updated running total
// (Q32.16, saturated). loss_mode (APB register at byte 0) selects half squared
// error (0) or cross entropy (1). After reset the block builds its ln table of
// LOG_TABLE_ENTRIES entries in an internal RAM, using the shared divider and
// multiplier; req_stall stays high meanwhile. A squared-error request needs
// one multiply; a cross-entropy request runs through the 42-step divider and
// the one-bit-per-cycle normalization. The block handles one request at a
// time; the response register frees the block to take the next request while
// the previous response still waits on rsp_stall.
module loss_and_gradient_unit #(
   parameter int LOG_TABLE_ENTRIES = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lgu_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lgu_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int KW = $clog2(LOG_TABLE_ENTRIES);

   // sequencer
   lgu_pkg::state_type state_ff, state_in;

   // configuration
   logic mode_ff;

   // table build
   logic [KW-1:0] kcnt_ff;
   logic [29:0]   z_ff;
   logic [29:0]   z2_ff;
   logic [29:0]   term_ff;
   logic [30:0]   sum_ff;
   logic [6:0]    d_ff;
   logic [15:0]   tab_mem [LOG_TABLE_ENTRIES];
   logic [15:0]   rd_ff;

   // request datapath
   logic signed [23:0] p_ff;
   logic signed [23:0] t_ff;
   logic               last_ff;
   logic               mode_lat_ff;
   logic [23:0]        x_ff;
   logic [23:0]        nrm_ff;
   logic [4:0]         e_ff;
   logic [KW-1:0]      idx_ff;
   logic signed [20:0] ln_ff;
   logic signed [31:0] grad_ff;
   logic signed [47:0] lterm_ff;

   // running state
   logic signed [47:0] partial_ff;
   logic signed [47:0] total_ff;

   // response register
   logic                     rsp_valid_ff;
   lgu_pkg::rsp_payload_type rsp_ff;

   // shared units
   logic                          div_start;
   logic [lgu_pkg::DIVD_W-1:0]    div_dividend;
   logic [lgu_pkg::DVSR_W-1:0]    div_divisor;
   logic [lgu_pkg::DIVD_W-1:0]    div_quo;
   logic                          div_done;
   logic signed [31:0]            mul_a;
   logic signed [31:0]            mul_b;
   logic signed [63:0]            product;

   logic               accept;
   logic               rsp_free;
   logic signed [24:0] diff;
   logic [24:0]        adiff;
   logic signed [24:0] neg_t;
   logic [23:0]        abs_t;
   logic signed [24:0] x_calc;
   logic               cfg_wr;

   // end-of-request accumulation
   logic signed [48:0] psum;
   logic signed [47:0] pnew;
   logic signed [47:0] vloss;
   logic signed [48:0] tsum;
   logic signed [47:0] tnew;
   logic signed [5:0]  e_off;

   lgu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign product = mul_a * mul_b;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign diff  = 25'(p_ff) - 25'(t_ff);
   assign adiff = diff[24] ? 25'(-diff) : 25'(diff);
   assign neg_t = -25'(t_ff);
   assign abs_t = t_ff[23] ? 24'(-25'(t_ff)) : 24'(t_ff);
   assign x_calc = 25'(req_payload.prediction) + 25'sd1;
   assign e_off  = $signed({1'b0, e_ff}) - 6'sd16;

   // config port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == lgu_pkg::REG_LOSS_MODE) ? {31'b0, mode_ff} : 32'b0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lgu_pkg::ST_FILL_ZS:   state_in = lgu_pkg::ST_FILL_ZW;
         lgu_pkg::ST_FILL_ZW:   if (div_done) state_in = lgu_pkg::ST_FILL_Z2;
         lgu_pkg::ST_FILL_Z2:   state_in = lgu_pkg::ST_FILL_LOOP;
         lgu_pkg::ST_FILL_LOOP: begin
            if (term_ff == '0 || d_ff >= 7'(lgu_pkg::TERM_MAX_D))
               state_in = lgu_pkg::ST_FILL_WR;
            else
               state_in = lgu_pkg::ST_FILL_TW;
         end
         lgu_pkg::ST_FILL_TW:   if (div_done) state_in = lgu_pkg::ST_FILL_TM;
         lgu_pkg::ST_FILL_TM:   state_in = lgu_pkg::ST_FILL_LOOP;
         lgu_pkg::ST_FILL_WR: begin
            if (kcnt_ff == KW'(LOG_TABLE_ENTRIES - 1))
               state_in = lgu_pkg::ST_IDLE;
            else
               state_in = lgu_pkg::ST_FILL_ZS;
         end
         lgu_pkg::ST_IDLE: begin
            if (accept)
               state_in = (mode_ff == lgu_pkg::MODE_XENT) ? lgu_pkg::ST_CE_DS
                                                          : lgu_pkg::ST_SE_MUL;
         end
         lgu_pkg::ST_SE_MUL:    state_in = lgu_pkg::ST_DONE;
         lgu_pkg::ST_CE_DS:     state_in = lgu_pkg::ST_CE_DW;
         lgu_pkg::ST_CE_DW:     if (div_done) state_in = lgu_pkg::ST_CE_NORM;
         lgu_pkg::ST_CE_NORM:   if (nrm_ff[23]) state_in = lgu_pkg::ST_CE_IDX;
         lgu_pkg::ST_CE_IDX:    state_in = lgu_pkg::ST_CE_RD;
         lgu_pkg::ST_CE_RD:     state_in = lgu_pkg::ST_CE_LN;
         lgu_pkg::ST_CE_LN:     state_in = lgu_pkg::ST_CE_MUL;
         lgu_pkg::ST_CE_MUL:    state_in = lgu_pkg::ST_DONE;
         lgu_pkg::ST_DONE:      if (rsp_free) state_in = lgu_pkg::ST_IDLE;
         default:               state_in = lgu_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer: unit operands and stall
   always_comb begin
      req_stall    = 1'b1;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         lgu_pkg::ST_IDLE: req_stall = 1'b0;
         lgu_pkg::ST_FILL_ZS: begin
            div_start    = 1'b1;
            div_dividend = lgu_pkg::DIVD_W'(kcnt_ff) << 30;
            div_divisor  = lgu_pkg::DVSR_W'(2 * LOG_TABLE_ENTRIES) +
                           lgu_pkg::DVSR_W'(kcnt_ff);
         end
         lgu_pkg::ST_FILL_Z2: begin
            mul_a = $signed({2'b0, z_ff});
            mul_b = $signed({2'b0, z_ff});
         end
         lgu_pkg::ST_FILL_LOOP: begin
            div_start    = (term_ff != '0) && (d_ff < 7'(lgu_pkg::TERM_MAX_D));
            div_dividend = lgu_pkg::DIVD_W'(term_ff);
            div_divisor  = lgu_pkg::DVSR_W'(d_ff);
         end
         lgu_pkg::ST_FILL_TM: begin
            mul_a = $signed({2'b0, term_ff});
            mul_b = $signed({2'b0, z2_ff});
         end
         lgu_pkg::ST_SE_MUL: begin
            mul_a = $signed({7'b0, adiff});
            mul_b = $signed({7'b0, adiff});
         end
         lgu_pkg::ST_CE_DS: begin
            div_start    = 1'b1;
            div_dividend = lgu_pkg::DIVD_W'(abs_t) << 16;
            div_divisor  = x_ff;
         end
         lgu_pkg::ST_CE_IDX: begin
            mul_a = $signed({9'b0, nrm_ff[22:0]});
            mul_b = 32'(LOG_TABLE_ENTRIES);
         end
         lgu_pkg::ST_CE_MUL: begin
            mul_a = 32'(neg_t);
            mul_b = 32'(ln_ff);
         end
         default: ;
      endcase
   end

   // saturating accumulation at the end of a request
   always_comb begin
      psum  = 49'(partial_ff) + 49'(lterm_ff);
      pnew  = (psum[48] != psum[47]) ? (psum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                                     : psum[47:0];
      vloss = (mode_lat_ff == lgu_pkg::MODE_XENT) ? pnew : (pnew >>> 1);
      tsum  = 49'(total_ff) + 49'(vloss);
      tnew  = (tsum[48] != tsum[47]) ? (tsum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}})
                                     : tsum[47:0];
   end

   // ln table RAM
   always_ff @(posedge clock) begin
      if (state_ff == lgu_pkg::ST_FILL_WR)
         tab_mem[kcnt_ff] <= 16'((({sum_ff, 1'b0}) + 32'd8192) >> 14);
      if (state_ff == lgu_pkg::ST_CE_RD)
         rd_ff <= tab_mem[idx_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgu_pkg::ST_FILL_ZS;
         kcnt_ff      <= '0;
         mode_ff      <= lgu_pkg::MODE_HALF_SQ;
         partial_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr && paddr[2] == lgu_pkg::REG_LOSS_MODE)
            mode_ff <= pwdata[0];
         if (state_ff == lgu_pkg::ST_FILL_WR)
            kcnt_ff <= kcnt_ff + KW'(1);
         if (state_ff == lgu_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            partial_ff   <= last_ff ? 48'sd0 : pnew;
            if (last_ff)
               total_ff <= tnew;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         lgu_pkg::ST_FILL_ZW: begin
            if (div_done) begin
               z_ff    <= div_quo[29:0];
               term_ff <= div_quo[29:0];
               sum_ff  <= '0;
               d_ff    <= 7'd1;
            end
         end
         lgu_pkg::ST_FILL_Z2: z2_ff <= product[59:30];
         lgu_pkg::ST_FILL_TW: if (div_done) sum_ff <= sum_ff + 31'(div_quo);
         lgu_pkg::ST_FILL_TM: begin
            term_ff <= product[59:30];
            d_ff    <= d_ff + 7'd2;
         end
         lgu_pkg::ST_IDLE: begin
            if (accept) begin
               p_ff        <= req_payload.prediction;
               t_ff        <= req_payload.target;
               last_ff     <= req_payload.last;
               mode_lat_ff <= mode_ff;
               // eps is one LSB; non-positive x clamps to one LSB
               x_ff <= (x_calc < 25'sd1) ? 24'd1 : x_calc[23:0];
            end
         end
         lgu_pkg::ST_SE_MUL: begin
            grad_ff  <= 32'(diff);
            lterm_ff <= product[63:16];
         end
         lgu_pkg::ST_CE_DS: begin
            nrm_ff <= x_ff;
            e_ff   <= 5'd23;
         end
         lgu_pkg::ST_CE_DW: begin
            if (div_done) begin
               if (t_ff == '0)
                  grad_ff <= '0;
               else if (!t_ff[23])
                  grad_ff <= (div_quo > lgu_pkg::DIVD_W'(64'h8000_0000))
                             ? 32'sh8000_0000 : 32'(-div_quo[31:0]);
               else
                  grad_ff <= (div_quo > lgu_pkg::DIVD_W'(64'h7FFF_FFFF))
                             ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
            end
         end
         lgu_pkg::ST_CE_NORM: begin
            if (!nrm_ff[23]) begin
               nrm_ff <= {nrm_ff[22:0], 1'b0};
               e_ff   <= e_ff - 5'd1;
            end
         end
         lgu_pkg::ST_CE_IDX: idx_ff <= product[23+KW-1:23];
         lgu_pkg::ST_CE_LN:
            ln_ff <= 21'($signed({5'b0, rd_ff})) +
                     21'(e_off) * 21'(lgu_pkg::LN2_Q16);
         lgu_pkg::ST_CE_MUL: lterm_ff <= product[63:16];
         lgu_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_ff.gradient    <= grad_ff;
               rsp_ff.vector_loss <= last_ff ? vloss : 48'sd0;
               rsp_ff.loss_total  <= last_ff ? tnew : total_ff;
               rsp_ff.done_res    <= last_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/lgu_div.sv @@
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module lgu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lgu_pkg::DIVD_W-1:0]   dividend,
   input  logic [lgu_pkg::DVSR_W-1:0]   divisor,
   output logic [lgu_pkg::DIVD_W-1:0]   quotient,
   output logic                         done
);

   localparam int CW = $clog2(lgu_pkg::DIVD_W + 1);

   logic [lgu_pkg::DVSR_W-1:0] rem_ff, rem_in;
   logic [lgu_pkg::DVSR_W-1:0] dvsr_ff;
   logic [lgu_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]              cnt_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [lgu_pkg::DVSR_W:0]   trial;
   logic                       ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[lgu_pkg::DIVD_W-1]};
      ge     = (trial >= {1'b0, dvsr_ff});
      rem_in = ge ? lgu_pkg::DVSR_W'(trial - {1'b0, dvsr_ff})
                  : trial[lgu_pkg::DVSR_W-1:0];
      quo_in = {quo_ff[lgu_pkg::DIVD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(lgu_pkg::DIVD_W);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvsr_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

@@ design/lgu_checker.sv @@
// Port-level checks for the loss and gradient unit, bound to the top level.
module lgu_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input lgu_pkg::rsp_payload_type rsp_payload
);

   // one request at a time: busy right after taking one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous request still in work");

   // vector loss only on a closing response
   a_vloss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.done_res |-> rsp_payload.vector_loss == 48'sd0)
      else $error("vector loss nonzero on non-closing response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

endmodule

bind loss_and_gradient_unit lgu_checker u_lgu_checker (.*);
